/* rtl/sft_pkg.sv */
package sft_pkg;

    // Field widths
    localparam int DATA_W = 32;
    localparam int ID_W   = 4;
    localparam int MODE_W = 2;
    localparam int THR_W  = 31;

    // Defaults
    localparam int                SENSOR_COUNT_DEF = 16;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = THR_W'(2000);

    // Request codes
    localparam logic [MODE_W-1:0] MODE_LOCAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BCAST  = 2'd2;

    // One table entry as kept in memory
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] tick;
        logic [DATA_W-1:0] stamp;
    } entry_t;

endpackage

/* rtl/sensor_freshness_table.sv */
// Sensor freshness table.
// Input channel (s_*): one request per transfer. Mode 0 stores a local reading
// and advances the local tick, mode 1 applies a remote update when its sensor
// tick is newer, mode 2 broadcasts every entry whose age is under the
// threshold, mode 3 does nothing. Result channel (m_*): one transfer per fresh
// entry of a broadcast, m_last set on the final one.
// Config channel (cfg_*): writes the staleness threshold; always ready.
// Sequence: an update is accepted, then the entry is read and written back
// through the table memory (one write port, one registered read port).
// A broadcast walks the memory one entry per cycle, with the receiver keeping
// up; the output lags the scan by one fresh entry, since the last flag is only
// known once the next fresh entry or the end of the table is seen.
// Stalls: when the output register is full and m_ready is low, the scan holds
// its place; the next request is taken once the scan has handed off its final
// result.
// Reset: clears the local tick, the threshold (to 2000) and the per-entry
// valid bits, so every entry reads as zero until written. No clearing pass.
module sensor_freshness_table #(
    parameter int SENSOR_COUNT = sft_pkg::SENSOR_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sft_pkg::MODE_W-1:0]  s_mode,
    input  logic [sft_pkg::ID_W-1:0]    s_sensor_id,
    input  logic signed [sft_pkg::DATA_W-1:0] s_sensor_value,
    input  logic signed [sft_pkg::DATA_W-1:0] s_sensor_tick,
    input  logic signed [sft_pkg::DATA_W-1:0] s_age_offset,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sft_pkg::ID_W-1:0]    m_out_id,
    output logic signed [sft_pkg::DATA_W-1:0] m_out_value,
    output logic signed [sft_pkg::DATA_W-1:0] m_out_tick,
    output logic signed [sft_pkg::DATA_W-1:0] m_out_age,
    output logic                        m_last,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sft_pkg::THR_W-1:0]   cfg_data
);
    import sft_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam logic [CNT_W-1:0] COUNT = CNT_W'(SENSOR_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UPD   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Control state
    logic [1:0]              state_reg, state_next;
    logic [DATA_W-1:0]       local_tick_reg, local_tick_next;
    logic [THR_W-1:0]        threshold_reg;
    logic [SENSOR_COUNT-1:0] vbit_reg, vbit_next;
    logic [CNT_W-1:0]        issue_cnt_reg, issue_cnt_next;
    logic                    dat_vld_reg, dat_vld_next;
    logic                    hold_vld_reg, hold_vld_next;
    logic                    m_valid_reg, m_valid_next;

    // Payload
    logic [MODE_W-1:0]       req_mode_reg, req_mode_next;
    logic [IDX_W-1:0]        req_id_reg, req_id_next;
    logic [DATA_W-1:0]       req_value_reg, req_value_next;
    logic [DATA_W-1:0]       req_tick_reg, req_tick_next;
    logic [DATA_W-1:0]       req_offs_reg, req_offs_next;
    logic [IDX_W-1:0]        dat_idx_reg, dat_idx_next;
    logic [ID_W-1:0]         hold_id_reg, hold_id_next;
    logic [DATA_W-1:0]       hold_value_reg, hold_value_next;
    logic [DATA_W-1:0]       hold_tick_reg, hold_tick_next;
    logic [DATA_W-1:0]       hold_age_reg, hold_age_next;
    logic [ID_W-1:0]         out_id_reg, out_id_next;
    logic [DATA_W-1:0]       out_value_reg, out_value_next;
    logic [DATA_W-1:0]       out_tick_reg, out_tick_next;
    logic [DATA_W-1:0]       out_age_reg, out_age_next;
    logic                    out_last_reg, out_last_next;

    // Table memory
    entry_t                  entry_mem [SENSOR_COUNT];
    entry_t                  rd_data_reg;
    logic                    rd_vbit_reg;
    logic                    rd_en, wr_en;
    logic [IDX_W-1:0]        rd_addr, wr_addr;
    entry_t                  wr_data;

    // Datapath helpers
    entry_t                  cur;
    logic [DATA_W-1:0]       age;
    logic                    fresh;
    logic                    out_free;
    logic                    advance;
    logic                    id_ok;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_out_id    = out_id_reg;
    assign m_out_value = out_value_reg;
    assign m_out_tick  = out_tick_reg;
    assign m_out_age   = out_age_reg;
    assign m_last      = out_last_reg;

    // Entry never written reads as zero
    assign cur   = rd_vbit_reg ? rd_data_reg : '0;
    assign age   = local_tick_reg - cur.stamp;
    assign fresh = $signed(age) < $signed({1'b0, threshold_reg});

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = !dat_vld_reg || !fresh || !hold_vld_reg || out_free;
    assign id_ok    = 32'(s_sensor_id) < 32'(SENSOR_COUNT);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        local_tick_next = local_tick_reg;
        vbit_next       = vbit_reg;
        issue_cnt_next  = issue_cnt_reg;
        dat_vld_next    = dat_vld_reg;
        hold_vld_next   = hold_vld_reg;
        m_valid_next    = m_valid_reg;
        req_mode_next   = req_mode_reg;
        req_id_next     = req_id_reg;
        req_value_next  = req_value_reg;
        req_tick_next   = req_tick_reg;
        req_offs_next   = req_offs_reg;
        dat_idx_next    = dat_idx_reg;
        hold_id_next    = hold_id_reg;
        hold_value_next = hold_value_reg;
        hold_tick_next  = hold_tick_reg;
        hold_age_next   = hold_age_reg;
        out_id_next     = out_id_reg;
        out_value_next  = out_value_reg;
        out_tick_next   = out_tick_reg;
        out_age_next    = out_age_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_cnt_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = req_id_reg;
        wr_data         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_mode_next  = s_mode;
                    req_id_next    = IDX_W'(s_sensor_id);
                    req_value_next = s_sensor_value;
                    req_tick_next  = s_sensor_tick;
                    req_offs_next  = s_age_offset;
                    if ((s_mode == MODE_LOCAL || s_mode == MODE_REMOTE) && id_ok) begin
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(s_sensor_id);
                        state_next = ST_UPD;
                    end else if (s_mode == MODE_BCAST) begin
                        issue_cnt_next = '0;
                        dat_vld_next   = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            // Read-modify-write of the addressed entry
            ST_UPD: begin
                state_next    = ST_IDLE;
                wr_data.value = req_value_reg;
                wr_data.tick  = req_tick_reg;
                if (req_mode_reg == MODE_LOCAL) begin
                    wr_en           = 1'b1;
                    wr_data.stamp   = local_tick_reg;
                    local_tick_next = local_tick_reg + DATA_W'(1);
                end else if ($signed(cur.tick) < $signed(req_tick_reg)) begin
                    wr_en         = 1'b1;
                    wr_data.stamp = local_tick_reg - req_offs_reg;
                end
                if (wr_en) begin
                    vbit_next[req_id_reg] = 1'b1;
                end
            end

            // Walk the table; keep one fresh entry back to know the last one
            ST_SCAN: begin
                if (advance) begin
                    if (issue_cnt_reg != COUNT) begin
                        rd_en          = 1'b1;
                        issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    end
                    dat_vld_next = rd_en;
                    dat_idx_next = issue_cnt_reg[IDX_W-1:0];
                    if (dat_vld_reg && fresh) begin
                        if (hold_vld_reg) begin
                            m_valid_next   = 1'b1;
                            out_id_next    = hold_id_reg;
                            out_value_next = hold_value_reg;
                            out_tick_next  = hold_tick_reg;
                            out_age_next   = hold_age_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_vld_next   = 1'b1;
                        hold_id_next    = ID_W'(dat_idx_reg);
                        hold_value_next = cur.value;
                        hold_tick_next  = cur.tick;
                        hold_age_next   = age;
                    end
                    if (issue_cnt_reg == COUNT && !dat_vld_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            // Hand off the final fresh entry with last set
            ST_FLUSH: begin
                if (!hold_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_id_next    = hold_id_reg;
                    out_value_next = hold_value_reg;
                    out_tick_next  = hold_tick_reg;
                    out_age_next   = hold_age_reg;
                    out_last_next  = 1'b1;
                    hold_vld_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            local_tick_reg <= '0;
            threshold_reg  <= THRESHOLD_RESET;
            vbit_reg       <= '0;
            issue_cnt_reg  <= '0;
            dat_vld_reg    <= 1'b0;
            hold_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            local_tick_reg <= local_tick_next;
            vbit_reg       <= vbit_next;
            issue_cnt_reg  <= issue_cnt_next;
            dat_vld_reg    <= dat_vld_next;
            hold_vld_reg   <= hold_vld_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                threshold_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_mode_reg   <= req_mode_next;
        req_id_reg     <= req_id_next;
        req_value_reg  <= req_value_next;
        req_tick_reg   <= req_tick_next;
        req_offs_reg   <= req_offs_next;
        dat_idx_reg    <= dat_idx_next;
        hold_id_reg    <= hold_id_next;
        hold_value_reg <= hold_value_next;
        hold_tick_reg  <= hold_tick_next;
        hold_age_reg   <= hold_age_next;
        out_id_reg     <= out_id_next;
        out_value_reg  <= out_value_next;
        out_tick_reg   <= out_tick_next;
        out_age_reg    <= out_age_next;
        out_last_reg   <= out_last_next;
    end

    // Table memory: one write, one registered read; read data holds when idle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
            rd_vbit_reg <= vbit_reg[rd_addr];
        end
    end

endmodule
